// ===== src/sws_pkg.sv =====
// Shared types and constants for the sliding window snapshot block.
`default_nettype none

package sws_pkg;

    localparam int NUM_AXES     = 6;
    localparam int OUT_AXIS_W   = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 1;
    localparam int PERIOD_W     = 10;
    localparam int STEP_W       = 16;
    localparam int COUNT_W      = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_STEP   = 1'd1;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd10;
    localparam logic [STEP_W-1:0]   STEP_RESET   = 16'd16;

    // Controller to datapath commands.
    typedef struct packed {
        logic take;       // input beat accepted: write ring, advance counters
        logic start;      // accepted beat opens a window
        logic issue;      // read next ring entry into the fetch stage
        logic last_beat;  // this read is the newest sample of the window
        logic load;       // move fetch stage into the output register
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic emit;       // a beat taken now would open a window
    } status_t;

endpackage

`default_nettype wire

// ===== src/sws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sws_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/sws_ctrl.sv =====
// Controller: input acceptance, window read sequencing, output stage valids.
`default_nettype none

module sws_ctrl #(
    parameter int WINDOW_SAMPLES = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  wire logic             out_stall,
    input  wire sws_pkg::status_t status,
    output sws_pkg::cmd_t         cmd
);

    localparam int IDX_W = $clog2(WINDOW_SAMPLES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SAMPLES - 1);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  beat_idx_reg, beat_idx_next;
    logic              f_valid_reg, f_valid_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd.take      = (state_reg == ST_IDLE) && in_valid;
        cmd.start     = cmd.take && status.emit;
        cmd.load      = f_valid_reg && (!out_valid_reg || !out_stall);
        cmd.issue     = (state_reg == ST_EMIT) && (!f_valid_reg || cmd.load);
        cmd.last_beat = cmd.issue && (beat_idx_reg == LAST_IDX);

        state_next    = state_reg;
        beat_idx_next = beat_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next    = ST_EMIT;
                    beat_idx_next = '0;
                end
            end
            ST_EMIT:
            begin
                if (cmd.issue)
                begin
                    beat_idx_next = beat_idx_reg + 1'b1;
                    if (cmd.last_beat)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.issue)
        begin
            f_valid_next = 1'b1;
        end
        else if (cmd.load)
        begin
            f_valid_next = 1'b0;
        end
        else
        begin
            f_valid_next = f_valid_reg;
        end

        out_valid_next = cmd.load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            beat_idx_reg  <= '0;
            f_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            beat_idx_reg  <= beat_idx_next;
            f_valid_reg   <= f_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== src/sws_datapath.sv =====
// Datapath: config registers, counters, sample ring, fetch and output stages.
`default_nettype none

module sws_datapath #(
    parameter int WINDOW_SAMPLES = 32,
    parameter int AXIS_BITS      = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire sws_pkg::cmd_t                       cmd,
    output sws_pkg::status_t                         status,
    input  wire logic                                cfg_we,
    input  wire logic [sws_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [sws_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic signed [sws_pkg::OUT_AXIS_W-1:0] gyro_x,
    input  wire logic signed [sws_pkg::OUT_AXIS_W-1:0] gyro_y,
    input  wire logic signed [sws_pkg::OUT_AXIS_W-1:0] gyro_z,
    input  wire logic signed [sws_pkg::OUT_AXIS_W-1:0] accel_x,
    input  wire logic signed [sws_pkg::OUT_AXIS_W-1:0] accel_y,
    input  wire logic signed [sws_pkg::OUT_AXIS_W-1:0] accel_z,
    output logic [sws_pkg::COUNT_W-1:0]              window_number,
    output logic [sws_pkg::COUNT_W-1:0]              sample_number,
    output logic [sws_pkg::COUNT_W-1:0]              stamp_ms,
    output logic signed [sws_pkg::OUT_AXIS_W-1:0]    out_gyro_x,
    output logic signed [sws_pkg::OUT_AXIS_W-1:0]    out_gyro_y,
    output logic signed [sws_pkg::OUT_AXIS_W-1:0]    out_gyro_z,
    output logic signed [sws_pkg::OUT_AXIS_W-1:0]    out_accel_x,
    output logic signed [sws_pkg::OUT_AXIS_W-1:0]    out_accel_y,
    output logic signed [sws_pkg::OUT_AXIS_W-1:0]    out_accel_z,
    output logic                                     last
);

    localparam int PTR_W  = $clog2(WINDOW_SAMPLES);
    localparam int ENTRY_W = sws_pkg::NUM_AXES * AXIS_BITS;
    localparam int CW     = sws_pkg::COUNT_W;
    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(WINDOW_SAMPLES - 1);
    localparam logic [CW-1:0]    FULL_AT  = CW'(WINDOW_SAMPLES - 1);
    // Oldest sample of the window ending at the next beat: counter - (W-1).
    localparam logic [CW-1:0]    TAIL_SN_RST =
        CW'(64'd4294967296 - 64'(WINDOW_SAMPLES - 1));
    localparam logic [PTR_W-1:0] TAIL_POS_RST =
        PTR_W'((64'd4294967296 - 64'(WINDOW_SAMPLES - 1)) % 64'(WINDOW_SAMPLES));

    // Ring position of sn+1 given position of sn: mod W, restarting at the 2^32 wrap.
    function automatic logic [PTR_W-1:0] pos_step(input logic [CW-1:0] sn,
                                                  input logic [PTR_W-1:0] pos);
        logic [PTR_W-1:0] r;
        if (sn == '1)
        begin
            r = '0;
        end
        else if (pos == LAST_POS)
        begin
            r = '0;
        end
        else
        begin
            r = pos + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [sws_pkg::OUT_AXIS_W-1:0] sext(
        input logic [AXIS_BITS-1:0] v);
        return sws_pkg::OUT_AXIS_W'($signed(v));
    endfunction

    // config
    logic [sws_pkg::PERIOD_W-1:0] period_reg;
    logic [sws_pkg::STEP_W-1:0]   step_reg;

    // stream state
    logic [CW-1:0]                sample_cnt_reg;
    logic [PTR_W-1:0]             wr_pos_reg;
    logic [CW-1:0]                tail_sn_reg;
    logic [PTR_W-1:0]             tail_pos_reg;
    logic [CW-1:0]                window_cnt_reg;
    logic [sws_pkg::STEP_W-1:0]   countdown_reg;
    logic                         ring_full_reg;

    // read walker
    logic [CW-1:0]                rd_sn_reg;
    logic [PTR_W-1:0]             rd_pos_reg;
    logic [CW-1:0]                emit_wnd_reg;

    // fetch stage (aligned with RAM read data)
    logic [CW-1:0]                f_sn_reg;
    logic [CW-1:0]                f_ts_reg;
    logic [CW-1:0]                f_wnd_reg;
    logic                         f_last_reg;

    // output stage
    logic [CW-1:0]                o_sn_reg;
    logic [CW-1:0]                o_ts_reg;
    logic [CW-1:0]                o_wnd_reg;
    logic                         o_last_reg;
    logic [ENTRY_W-1:0]           o_axes_reg;

    logic [ENTRY_W-1:0]           wr_entry;
    logic [ENTRY_W-1:0]           rd_entry;
    logic [CW+sws_pkg::PERIOD_W-1:0] ts_prod;
    logic                         emit;

    always_comb
    begin
        if (!ring_full_reg)
        begin
            emit = (sample_cnt_reg >= FULL_AT);
        end
        else
        begin
            emit = (countdown_reg == '0);
        end
        status.emit = emit;
    end

    assign wr_entry = {accel_z[AXIS_BITS-1:0], accel_y[AXIS_BITS-1:0],
                       accel_x[AXIS_BITS-1:0], gyro_z[AXIS_BITS-1:0],
                       gyro_y[AXIS_BITS-1:0],  gyro_x[AXIS_BITS-1:0]};

    assign ts_prod = rd_sn_reg * period_reg;

    sws_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW_SAMPLES)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.take),
        .waddr (wr_pos_reg),
        .wdata (wr_entry),
        .re    (cmd.issue),
        .raddr (rd_pos_reg),
        .rdata (rd_entry)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= sws_pkg::PERIOD_RESET;
            step_reg       <= sws_pkg::STEP_RESET;
            sample_cnt_reg <= '0;
            wr_pos_reg     <= '0;
            tail_sn_reg    <= TAIL_SN_RST;
            tail_pos_reg   <= TAIL_POS_RST;
            window_cnt_reg <= '0;
            countdown_reg  <= '0;
            ring_full_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sws_pkg::REG_SAMPLE_PERIOD:
                    begin
                        period_reg <= cfg_data[sws_pkg::PERIOD_W-1:0];
                    end
                    sws_pkg::REG_WINDOW_STEP:
                    begin
                        step_reg <= cfg_data[sws_pkg::STEP_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.take)
            begin
                sample_cnt_reg <= sample_cnt_reg + 1'b1;
                wr_pos_reg     <= pos_step(sample_cnt_reg, wr_pos_reg);
                tail_sn_reg    <= tail_sn_reg + 1'b1;
                tail_pos_reg   <= pos_step(tail_sn_reg, tail_pos_reg);
                if (emit)
                begin
                    ring_full_reg  <= 1'b1;
                    countdown_reg  <= step_reg - 1'b1;   // zero step gives 0xFFFF
                    window_cnt_reg <= window_cnt_reg + 1'b1;
                end
                else if (ring_full_reg)
                begin
                    countdown_reg <= countdown_reg - 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rd_sn_reg    <= tail_sn_reg;
            rd_pos_reg   <= tail_pos_reg;
            emit_wnd_reg <= window_cnt_reg;
        end
        else if (cmd.issue)
        begin
            rd_sn_reg  <= rd_sn_reg + 1'b1;
            rd_pos_reg <= pos_step(rd_sn_reg, rd_pos_reg);
        end

        if (cmd.issue)
        begin
            f_sn_reg   <= rd_sn_reg;
            f_ts_reg   <= ts_prod[CW-1:0];
            f_wnd_reg  <= emit_wnd_reg;
            f_last_reg <= cmd.last_beat;
        end

        if (cmd.load)
        begin
            o_sn_reg   <= f_sn_reg;
            o_ts_reg   <= f_ts_reg;
            o_wnd_reg  <= f_wnd_reg;
            o_last_reg <= f_last_reg;
            o_axes_reg <= rd_entry;
        end
    end

    assign window_number = o_wnd_reg;
    assign sample_number = o_sn_reg;
    assign stamp_ms      = o_ts_reg;
    assign last          = o_last_reg;
    assign out_gyro_x    = sext(o_axes_reg[0*AXIS_BITS +: AXIS_BITS]);
    assign out_gyro_y    = sext(o_axes_reg[1*AXIS_BITS +: AXIS_BITS]);
    assign out_gyro_z    = sext(o_axes_reg[2*AXIS_BITS +: AXIS_BITS]);
    assign out_accel_x   = sext(o_axes_reg[3*AXIS_BITS +: AXIS_BITS]);
    assign out_accel_y   = sext(o_axes_reg[4*AXIS_BITS +: AXIS_BITS]);
    assign out_accel_z   = sext(o_axes_reg[5*AXIS_BITS +: AXIS_BITS]);

endmodule

`default_nettype wire

// ===== src/sliding_window_snapshot.sv =====
// Top level of the sliding window snapshot block.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+--------------------------------------
//   in       | sink      | in_valid / in_stall   | gyro_x..z, accel_x..z
//   out      | source    | out_valid / out_stall | window/sample number, stamp_ms, axes, last
//   cfg      | sink      | cfg_we                | cfg_index, cfg_data
//
// An input beat is written into the ring when it is accepted. A beat that closes a
// window is followed by WINDOW_SAMPLES output beats, one per cycle with no
// output stall; the single ring read port sets this. The first result passes
// through the ring read, the fetch stage and the output register.
// in_stall stays high while the window's ring reads are being issued.
// Output stall freezes the fetch and output stages in place; no beat is lost.
// Reset (rst_n low, asynchronous) clears counters, ring-full flag and valids;
// ring contents are not cleared and are never read before being written.
`default_nettype none

module sliding_window_snapshot #(
    parameter int WINDOW_SAMPLES = 32,
    parameter int AXIS_BITS      = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // config write port
    input  wire logic                                  cfg_we,
    input  wire logic [sws_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [sws_pkg::CFG_DATA_W-1:0]        cfg_data,
    // sample input
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [sws_pkg::OUT_AXIS_W-1:0] gyro_x,
    input  wire logic signed [sws_pkg::OUT_AXIS_W-1:0] gyro_y,
    input  wire logic signed [sws_pkg::OUT_AXIS_W-1:0] gyro_z,
    input  wire logic signed [sws_pkg::OUT_AXIS_W-1:0] accel_x,
    input  wire logic signed [sws_pkg::OUT_AXIS_W-1:0] accel_y,
    input  wire logic signed [sws_pkg::OUT_AXIS_W-1:0] accel_z,
    // window output
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [sws_pkg::COUNT_W-1:0]                window_number,
    output logic [sws_pkg::COUNT_W-1:0]                sample_number,
    output logic [sws_pkg::COUNT_W-1:0]                stamp_ms,
    output logic signed [sws_pkg::OUT_AXIS_W-1:0]      out_gyro_x,
    output logic signed [sws_pkg::OUT_AXIS_W-1:0]      out_gyro_y,
    output logic signed [sws_pkg::OUT_AXIS_W-1:0]      out_gyro_z,
    output logic signed [sws_pkg::OUT_AXIS_W-1:0]      out_accel_x,
    output logic signed [sws_pkg::OUT_AXIS_W-1:0]      out_accel_y,
    output logic signed [sws_pkg::OUT_AXIS_W-1:0]      out_accel_z,
    output logic                                       last
);

    sws_pkg::cmd_t    cmd;
    sws_pkg::status_t status;

    // Sequencer: accepts samples, walks the ring, keeps the two stage valids.
    sws_ctrl #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Ring, counters, timestamp multiply and output register.
    sws_datapath #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES),
        .AXIS_BITS      (AXIS_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .gyro_x        (gyro_x),
        .gyro_y        (gyro_y),
        .gyro_z        (gyro_z),
        .accel_x       (accel_x),
        .accel_y       (accel_y),
        .accel_z       (accel_z),
        .window_number (window_number),
        .sample_number (sample_number),
        .stamp_ms      (stamp_ms),
        .out_gyro_x    (out_gyro_x),
        .out_gyro_y    (out_gyro_y),
        .out_gyro_z    (out_gyro_z),
        .out_accel_x   (out_accel_x),
        .out_accel_y   (out_accel_y),
        .out_accel_z   (out_accel_z),
        .last          (last)
    );

endmodule

`default_nettype wire

// ===== src/sws_checker.sv =====
// Port-level checks for the sliding window snapshot block, bound to the top.
`default_nettype none

module sws_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] window_number,
    input wire logic [31:0] sample_number,
    input wire logic        last
);

    logic        mid_window_reg;
    logic [31:0] prev_sn_reg;
    logic [31:0] prev_wnd_reg;
    logic        out_take;

    assign out_take = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_window_reg <= 1'b0;
            prev_sn_reg    <= '0;
            prev_wnd_reg   <= '0;
        end
        else if (out_take)
        begin
            mid_window_reg <= !last;
            prev_sn_reg    <= sample_number;
            prev_wnd_reg   <= window_number;
        end
    end

    // A stalled beat holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_number) && $stable(last))
        else $error("stalled output beat changed");

    // Within a window, samples come in consecutive order.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_take && mid_window_reg |-> sample_number == prev_sn_reg + 32'd1)
        else $error("window samples not consecutive");

    // All beats of one window carry the same window number.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_take && mid_window_reg |-> window_number == prev_wnd_reg)
        else $error("window number changed inside a window");

    // After a window ends, the next window has the next number.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_take && !mid_window_reg && $past(rst_n) && prev_sn_reg != sample_number
        && prev_wnd_reg != window_number |-> window_number == prev_wnd_reg + 32'd1)
        else $error("window number skipped");

endmodule

bind sliding_window_snapshot sws_checker u_sws_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .window_number (window_number),
    .sample_number (sample_number),
    .last          (last)
);

`default_nettype wire
